// ===== rtl/pixel_pair_decision_tree_walk_defines.svh =====
// assertion macros for the decision tree walk block
// depends on clk and rst_n being visible at the point of use
`ifndef PIXEL_PAIR_DECISION_TREE_WALK_DEFINES_SVH
`define PIXEL_PAIR_DECISION_TREE_WALK_DEFINES_SVH

// same-cycle implication
`define PPTW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPTW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pptw_pkg.sv =====
// shared constants, codes and types of the decision tree walk block
// no dependencies
package pptw_pkg;

    localparam int MAX_DEPTH  = 10;
    localparam int CHANNELS   = 4;
    localparam int IMG_W      = 64;
    localparam int IMG_H      = 64;

    localparam int NODE_COUNT = (1 << (MAX_DEPTH + 1)) - 1;
    localparam int NODE_AW    = $clog2(NODE_COUNT);
    localparam int PIX_COUNT  = CHANNELS * IMG_H * IMG_W;
    localparam int PIX_AW     = $clog2(PIX_COUNT);

    localparam int IDX_W      = 11;

    localparam logic [1:0] KIND_NODE  = 2'd0;
    localparam logic [1:0] KIND_PIX   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_RANGE  = 2'd1;
    localparam logic [1:0] ERR_DEPTH  = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [10:0]       node_index;
        logic              is_leaf;
        logic [1:0]        channel;
        logic [5:0]        off_x1;
        logic [5:0]        off_y1;
        logic [5:0]        off_x2;
        logic [5:0]        off_y2;
        logic signed [9:0] threshold;
        logic [5:0]        pos_x;
        logic [5:0]        pos_y;
        logic [7:0]        pixel_value;
    } req_word_t;

    typedef struct packed {
        logic              leaf;
        logic [1:0]        chan;
        logic [5:0]        x1;
        logic [5:0]        y1;
        logic [5:0]        x2;
        logic [5:0]        y2;
        logic [9:0]        thr;
    } node_t;

    typedef struct packed {
        logic       wr_node;
        logic       wr_pix;
        logic       load_query;
        logic       fetch;
        logic       read_pix;
        logic       step;
        logic       finish;
        logic [1:0] err;
    } ctrl_cmd_t;

    typedef struct packed {
        logic leaf;
        logic range_err;
        logic depth_err;
    } dp_status_t;

endpackage

// ===== rtl/pptw_req_if.sv =====
// request channel: write node, write pixel or query words
// no dependencies
interface pptw_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [10:0]       node_index;
    logic              is_leaf;
    logic [1:0]        channel;
    logic [5:0]        off_x1;
    logic [5:0]        off_y1;
    logic [5:0]        off_x2;
    logic [5:0]        off_y2;
    logic signed [9:0] threshold;
    logic [5:0]        pos_x;
    logic [5:0]        pos_y;
    logic [7:0]        pixel_value;

    modport source (
        output valid, kind, node_index, is_leaf, channel, off_x1, off_y1, off_x2, off_y2,
               threshold, pos_x, pos_y, pixel_value,
        input  ready
    );
    modport sink (
        input  valid, kind, node_index, is_leaf, channel, off_x1, off_y1, off_x2, off_y2,
               threshold, pos_x, pos_y, pixel_value,
        output ready
    );
endinterface

// ===== rtl/pptw_rsp_if.sv =====
// response channel: leaf index and error code of one query
// no dependencies
interface pptw_rsp_if;
    logic        valid;
    logic        ready;
    logic [10:0] leaf_index;
    logic [1:0]  error;

    modport source (
        output valid, leaf_index, error,
        input  ready
    );
    modport sink (
        input  valid, leaf_index, error,
        output ready
    );
endinterface

// ===== rtl/pixel_pair_decision_tree_walk.sv =====
// top level of the pixel pair decision tree walk block
// depends on pptw_pkg, pptw_req_if, pptw_rsp_if, pptw_ctrl, pptw_datapath and the defines header
//
//   channel  dir  word
//   req      in   node write, pixel write or query (kind selects)
//   rsp      out  leaf_index and error, one per query
//
// node and pixel writes are taken in the idle state and can follow back to back
// a query goes through node fetch, decode with pixel pair read and compare for each inner
// node on its path, and through fetch, decode and result load for the last node; a walk
// past the last level ends from its compare, a range error from its decode; every word is taken in idle
// the result register holds one finished word; a new word is taken while it waits
// a walk that finishes while the result is still held waits until it is taken
// no clearing pass after reset: stores hold garbage until written
`include "pixel_pair_decision_tree_walk_defines.svh"

module pixel_pair_decision_tree_walk
    import pptw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    pptw_req_if.sink  req,
    pptw_rsp_if.source rsp
);

    req_word_t  req_word;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign req_word = '{
        kind:        req.kind,
        node_index:  req.node_index,
        is_leaf:     req.is_leaf,
        channel:     req.channel,
        off_x1:      req.off_x1,
        off_y1:      req.off_y1,
        off_x2:      req.off_x2,
        off_y2:      req.off_y2,
        threshold:   req.threshold,
        pos_x:       req.pos_x,
        pos_y:       req.pos_y,
        pixel_value: req.pixel_value
    };

    pptw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_kind   (req.kind),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    pptw_datapath u_datapath (
        .clk        (clk),
        .req_word   (req_word),
        .cmd        (cmd),
        .status     (status),
        .leaf_index (rsp.leaf_index),
        .error      (rsp.error)
    );

    `PPTW_ASSERT_NOW(a_err_zero_idx, rsp.valid && (rsp.error != ERR_NONE), rsp.leaf_index == '0, "error word carries a nonzero leaf index")
    `PPTW_ASSERT_NOW(a_no_overwrite, cmd.finish, !rsp.valid || rsp.ready, "result register overwritten while held")
    `PPTW_ASSERT_NOW(a_idle_accept, req.valid && req.ready, !cmd.fetch && !cmd.read_pix && !cmd.step, "word accepted during a walk")
    `PPTW_ASSERT_NEXT(a_fetch_decode, cmd.fetch, !cmd.fetch && !cmd.step && !req.ready, "node fetch not followed by decode")

endmodule

// ===== rtl/pptw_datapath.sv =====
// datapath: node store, pixel store, walk index, pixel test and result register
// depends on pptw_pkg
module pptw_datapath
    import pptw_pkg::*;
(
    input  logic        clk,
    input  req_word_t   req_word,
    input  ctrl_cmd_t   cmd,
    output dp_status_t  status,
    output logic [10:0] leaf_index,
    output logic [1:0]  error
);

    node_t              node_mem [NODE_COUNT];
    logic [7:0]         pix_mem  [PIX_COUNT];

    node_t              node_q_reg;
    logic [7:0]         pix_a_reg;
    logic [7:0]         pix_b_reg;
    logic [NODE_AW-1:0] idx_reg;
    logic [5:0]         base_x_reg;
    logic [5:0]         base_y_reg;
    logic [10:0]        res_idx_reg;
    logic [1:0]         res_err_reg;

    logic [6:0]         ax;
    logic [6:0]         ay;
    logic [6:0]         bx;
    logic [6:0]         by;
    logic               chan_ok;
    logic               a_ok;
    logic               b_ok;
    logic [PIX_AW-1:0]  addr_a;
    logic [PIX_AW-1:0]  addr_b;
    logic [PIX_AW-1:0]  addr_w;
    logic               wr_pix_ok;
    logic               wr_node_ok;
    logic signed [10:0] diff;
    logic signed [10:0] thr_ext;
    logic               pass;
    logic [NODE_AW:0]   next_idx;

    function automatic logic [PIX_AW-1:0] pix_addr(
        input logic [1:0] c,
        input logic [6:0] x,
        input logic [6:0] y
    );
        pix_addr = PIX_AW'((32'(c) * IMG_H + 32'(y)) * IMG_W + 32'(x));
    endfunction

    // test pixel coordinates
    assign ax = {1'b0, base_x_reg} + {1'b0, node_q_reg.x1};
    assign ay = {1'b0, base_y_reg} + {1'b0, node_q_reg.y1};
    assign bx = {1'b0, base_x_reg} + {1'b0, node_q_reg.x2};
    assign by = {1'b0, base_y_reg} + {1'b0, node_q_reg.y2};

    assign chan_ok = 32'(node_q_reg.chan) < CHANNELS;
    assign a_ok    = (32'(ax) < IMG_W) && (32'(ay) < IMG_H);
    assign b_ok    = (32'(bx) < IMG_W) && (32'(by) < IMG_H);

    assign addr_a = pix_addr(node_q_reg.chan, ax, ay);
    assign addr_b = pix_addr(node_q_reg.chan, bx, by);
    assign addr_w = pix_addr(req_word.channel, {1'b0, req_word.pos_x}, {1'b0, req_word.pos_y});

    assign wr_pix_ok  = (32'(req_word.channel) < CHANNELS) && (32'(req_word.pos_x) < IMG_W)
                        && (32'(req_word.pos_y) < IMG_H);
    assign wr_node_ok = 32'(req_word.node_index) < NODE_COUNT;

    // pixel pair test and child selection
    assign diff     = $signed({3'b000, pix_a_reg}) - $signed({3'b000, pix_b_reg});
    assign thr_ext  = $signed({node_q_reg.thr[9], node_q_reg.thr});
    assign pass     = diff >= thr_ext;
    assign next_idx = {idx_reg, 1'b0} + (NODE_AW + 1)'(1) + (NODE_AW + 1)'(pass);

    assign status.leaf      = node_q_reg.leaf;
    assign status.range_err = !(chan_ok && a_ok && b_ok);
    assign status.depth_err = 32'(next_idx) >= NODE_COUNT;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_node && wr_node_ok)
        begin
            node_mem[NODE_AW'(req_word.node_index)] <= '{
                leaf: req_word.is_leaf,
                chan: req_word.channel,
                x1:   req_word.off_x1,
                y1:   req_word.off_y1,
                x2:   req_word.off_x2,
                y2:   req_word.off_y2,
                thr:  req_word.threshold
            };
        end
        if (cmd.fetch)
        begin
            node_q_reg <= node_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_pix && wr_pix_ok)
        begin
            pix_mem[addr_w] <= req_word.pixel_value;
        end
        if (cmd.read_pix)
        begin
            pix_a_reg <= pix_mem[addr_a];
            pix_b_reg <= pix_mem[addr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            base_x_reg <= req_word.pos_x;
            base_y_reg <= req_word.pos_y;
            idx_reg    <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg <= next_idx[NODE_AW-1:0];
        end
        if (cmd.finish)
        begin
            res_err_reg <= cmd.err;
            res_idx_reg <= (cmd.err == ERR_NONE) ? IDX_W'(idx_reg) : '0;
        end
    end

    assign leaf_index = res_idx_reg;
    assign error      = res_err_reg;

endmodule

// ===== rtl/pptw_ctrl.sv =====
// controller: walk sequencer and output valid flag
// depends on pptw_pkg
module pptw_ctrl
    import pptw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_kind,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FETCH  = 3'd1;
    localparam logic [2:0] S_DECODE = 3'd2;
    localparam logic [2:0] S_CMP    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] err_reg;
    logic [1:0] err_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        err_next   = err_reg;
        cmd        = '0;
        cmd.err    = err_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    unique case (in_kind)
                        KIND_NODE:
                        begin
                            cmd.wr_node = 1'b1;
                        end
                        KIND_PIX:
                        begin
                            cmd.wr_pix = 1'b1;
                        end
                        KIND_QUERY:
                        begin
                            cmd.load_query = 1'b1;
                            err_next       = ERR_NONE;
                            state_next     = S_FETCH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_DECODE;
            end
            S_DECODE:
            begin
                priority if (status.leaf)
                begin
                    state_next = S_DONE;
                end
                else if (status.range_err)
                begin
                    err_next   = ERR_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.read_pix = 1'b1;
                    state_next   = S_CMP;
                end
            end
            S_CMP:
            begin
                if (status.depth_err)
                begin
                    err_next   = ERR_DEPTH;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
